[hw/rtl/sss_pkg.sv]
// shared types and constants for the sorted set statistics block
package sss_pkg;

  localparam int OUT_COUNT_W   = 8;
  localparam int OUT_VALUE_W   = 16;
  localparam int OUT_AVG_W     = 24;
  localparam int AVG_FRAC_BITS = 8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_FINISH
  } sss_state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } sss_cmd_t;

endpackage

[hw/rtl/sss_cell.sv]
// one cell of the sorting chain: holds one value and its occupied bit
module sss_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sss_pkg::sss_cmd_t            cmd,
  input  logic signed [VALUE_BITS-1:0] new_val,
  input  logic signed [VALUE_BITS-1:0] left_val,
  input  logic                         left_occ,
  input  logic                         left_gt,
  input  logic signed [VALUE_BITS-1:0] right_val,
  input  logic                         right_occ,
  output logic signed [VALUE_BITS-1:0] val,
  output logic                         occ,
  output logic                         gt
);
  import sss_pkg::*;

  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic                         occ_r, occ_nxt;

  assign gt  = occ_r && (val_r > new_val);
  assign val = val_r;
  assign occ = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.ins) begin
      // larger values move one place right, the new word lands at the boundary
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || (!occ_r && left_occ)) begin
        val_nxt = new_val;
      end
      occ_nxt = occ_r || left_occ;
    end else if (cmd.shift) begin
      val_nxt = right_val;
      occ_nxt = right_occ;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

[hw/rtl/sss_div.sv]
// restoring divider, one quotient bit per cycle
module sss_div #(
  parameter int DW = 32,
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  import sss_pkg::*;

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [NW-1:0] dvs_r, dvs_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [NW+1:0] rem_sh;

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r, quo_r[DW-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = KW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {2'b00, dvs_r}) begin
        rem_nxt = (NW + 1)'(rem_sh - {2'b00, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[NW:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/sorted_set_statistics_top.sv]
// Sorted set statistics: count, min, max, median and mean of a stream of signed words.
// Input channel: one signed word per handshake on in_valid/in_stall, in_set_end marks the
// last word of a set. Words go into a chain of MAX_ITEMS cells, one insertion a cycle, so
// in_stall stays low for the whole set. Words beyond MAX_ITEMS are dropped and flagged.
// After the last word the chain drains toward cell 0 one place a cycle,
// picking off min, max and the two middle values, while a restoring divider forms
// sum*256/count. in_stall is high meanwhile. The result is loaded once both the drain
// and the divider are done. Results sit in an output register: the next set is taken
// as soon as the result is loaded, even while out_stall holds it. If the previous result
// is still held when a new one is ready, the block waits with in_stall high. A stalled
// result keeps its fields. Reset (rst_n low at a clock edge) empties the chain, clears
// count, sum and the overflow flag and drops any pending result.
module sorted_set_statistics_top #(
  parameter int MAX_ITEMS  = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [VALUE_BITS-1:0]            in_sample_value,
  input  logic                                    in_set_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [sss_pkg::OUT_COUNT_W-1:0]         out_item_count,
  output logic signed [sss_pkg::OUT_VALUE_W-1:0]  out_smallest,
  output logic signed [sss_pkg::OUT_VALUE_W-1:0]  out_largest,
  output logic signed [sss_pkg::OUT_VALUE_W-1:0]  out_middle_value,
  output logic signed [sss_pkg::OUT_AVG_W-1:0]    out_average_q8,
  output logic                                    out_overflowed
);
  import sss_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = VALUE_BITS + CW;
  localparam int DW = SW + AVG_FRAC_BITS;

  sss_state_t state_r, state_nxt;

  logic [CW-1:0]                count_r, count_nxt;
  logic signed [SW-1:0]         sum_r, sum_nxt;
  logic                         drop_r, drop_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic signed [VALUE_BITS-1:0] min_r, max_r, mida_r, midb_r;
  logic signed [VALUE_BITS-1:0] min_nxt, max_nxt, mida_nxt, midb_nxt;

  logic                                 ovalid_r, ovalid_nxt;
  logic [OUT_COUNT_W-1:0]               ocount_r, ocount_nxt;
  logic signed [OUT_VALUE_W-1:0]        omin_r, omin_nxt, omax_r, omax_nxt;
  logic signed [OUT_VALUE_W-1:0]        omid_r, omid_nxt;
  logic signed [OUT_AVG_W-1:0]          oavg_r, oavg_nxt;
  logic                                 oovf_r, oovf_nxt;

  sss_cmd_t                     cmd;
  logic signed [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]         cell_occ;
  logic [MAX_ITEMS-1:0]         cell_gt;

  logic                         accept;
  logic                         full;
  logic [CW-1:0]                last_idx, lo_idx, hi_idx;
  logic                         div_start, div_busy;
  logic [DW-1:0]                div_quo;
  logic [SW-1:0]                sum_mag;
  logic signed [VALUE_BITS:0]   mid_sum, mid_half;
  logic signed [DW:0]           avg_full;
  logic                         out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign full     = (count_r == CW'(MAX_ITEMS));
  assign last_idx = count_r - 1'b1;
  assign lo_idx   = last_idx >> 1;
  assign hi_idx   = count_r >> 1;
  assign out_free = !ovalid_r || !out_stall;

  // the sorting chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] lv, rv;
    logic                         lo, lg, ro;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b1;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    sss_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .new_val  (in_sample_value),
      .left_val (lv),
      .left_occ (lo),
      .left_gt  (lg),
      .right_val(rv),
      .right_occ(ro),
      .val      (cell_val[i]),
      .occ      (cell_occ[i]),
      .gt       (cell_gt[i])
    );
  end

  // mean: magnitude of sum*256 over count, sign put back afterwards
  assign sum_mag   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign div_start = (state_r == ST_DRAIN) && (k_r == '0);

  sss_div #(
    .DW(DW),
    .NW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend({sum_mag, {AVG_FRAC_BITS{1'b0}}}),
    .divisor (count_r),
    .busy    (div_busy),
    .quotient(div_quo)
  );

  assign avg_full = sum_r[SW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // median halves toward zero
  assign mid_sum  = (VALUE_BITS + 1)'(mida_r) + (VALUE_BITS + 1)'(midb_r);
  assign mid_half = (mid_sum + $signed({{VALUE_BITS{1'b0}}, mid_sum[VALUE_BITS]})) >>> 1;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    drop_nxt   = drop_r;
    k_nxt      = k_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    mida_nxt   = mida_r;
    midb_nxt   = midb_r;
    ovalid_nxt = ovalid_r;
    ocount_nxt = ocount_r;
    omin_nxt   = omin_r;
    omax_nxt   = omax_r;
    omid_nxt   = omid_r;
    oavg_nxt   = oavg_r;
    oovf_nxt   = oovf_r;
    cmd        = '0;

    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + SW'(in_sample_value);
          end
          if (in_set_end) begin
            state_nxt = ST_DRAIN;
            k_nxt     = '0;
          end
        end
      end
      ST_DRAIN: begin
        // cell 0 holds the k-th smallest word
        cmd.shift = 1'b1;
        if (k_r == '0) begin
          min_nxt = cell_val[0];
        end
        if (k_r == lo_idx) begin
          mida_nxt = cell_val[0];
        end
        if (k_r == hi_idx) begin
          midb_nxt = cell_val[0];
        end
        if (k_r == last_idx) begin
          max_nxt   = cell_val[0];
          state_nxt = ST_FINISH;
        end
        k_nxt = k_r + 1'b1;
      end
      ST_FINISH: begin
        if (!div_busy && out_free) begin
          ovalid_nxt = 1'b1;
          ocount_nxt = OUT_COUNT_W'(count_r);
          omin_nxt   = OUT_VALUE_W'(min_r);
          omax_nxt   = OUT_VALUE_W'(max_r);
          omid_nxt   = OUT_VALUE_W'(mid_half);
          oavg_nxt   = OUT_AVG_W'(avg_full);
          oovf_nxt   = drop_r;
          count_nxt  = '0;
          sum_nxt    = '0;
          drop_nxt   = 1'b0;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    mida_r   <= mida_nxt;
    midb_r   <= midb_nxt;
    ocount_r <= ocount_nxt;
    omin_r   <= omin_nxt;
    omax_r   <= omax_nxt;
    omid_r   <= omid_nxt;
    oavg_r   <= oavg_nxt;
    oovf_r   <= oovf_nxt;
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      sum_r    <= '0;
      drop_r   <= 1'b0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      drop_r   <= drop_nxt;
      k_r      <= k_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_item_count   = ocount_r;
  assign out_smallest     = omin_r;
  assign out_largest      = omax_r;
  assign out_middle_value = omid_r;
  assign out_average_q8   = oavg_r;
  assign out_overflowed   = oovf_r;

`ifndef NO_ASSERTIONS
  // occupied cells match the word count while loading
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> ($countones(cell_occ) == 32'(count_r)))
    else $error("chain occupancy does not match word count");

  // the drain leaves the chain empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (cell_occ == '0))
    else $error("chain not empty after drain");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("word count beyond capacity");

  // a result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_stall) |=> (ocount_r == $past(ocount_r) && oavg_r == $past(oavg_r)))
    else $error("held result overwritten");
`endif

endmodule

[tb/tb_sorted_set_statistics_top.sv]
// testbench for sorted_set_statistics_top: directed and random sets of signed words checked by a scoreboard
`timescale 1ns / 1ps

module tb_sorted_set_statistics_top;

  localparam int SET_DEPTH  = 128;
  localparam int WORD_W     = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;
  localparam int WORD_TARGET = 1600;

  typedef struct packed {
    logic [sss_pkg::OUT_COUNT_W-1:0]        count;
    logic signed [sss_pkg::OUT_VALUE_W-1:0] smallest;
    logic signed [sss_pkg::OUT_VALUE_W-1:0] largest;
    logic signed [sss_pkg::OUT_VALUE_W-1:0] median;
    logic signed [sss_pkg::OUT_AVG_W-1:0]   mean_q8;
    logic                                   dropped;
  } set_stats_t;

  class set_stats_board;
    logic signed [WORD_W-1:0] sorted_words[$];
    longint                   word_sum;
    bit                       words_dropped;
    set_stats_t               expected_stats[$];
    int                       errors;

    function new();
      word_sum      = 0;
      words_dropped = 0;
      errors        = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // keeps the set in ascending order, equal words go after their peers
    task note_word(logic signed [WORD_W-1:0] w, logic last);
      int         pos;
      int         n;
      int         lo;
      int         hi;
      longint     mean;
      set_stats_t e;
      if (sorted_words.size() < SET_DEPTH) begin
        pos = sorted_words.size();
        while (pos > 0 && sorted_words[pos-1] > w) pos--;
        sorted_words.insert(pos, w);
        word_sum += longint'(w);
      end else begin
        words_dropped = 1;
      end
      if (last) begin
        n = sorted_words.size();
        e.count    = n[sss_pkg::OUT_COUNT_W-1:0];
        e.smallest = sorted_words[0];
        e.largest  = sorted_words[n-1];
        if (n % 2 == 1) begin
          e.median = sorted_words[n/2];
        end else begin
          lo = sorted_words[n/2-1];
          hi = sorted_words[n/2];
          lo = (lo + hi) / 2;
          e.median = lo[WORD_W-1:0];
        end
        mean = (word_sum * 256) / longint'(n);
        e.mean_q8 = mean[sss_pkg::OUT_AVG_W-1:0];
        e.dropped = words_dropped;
        expected_stats.push_back(e);
        sorted_words.delete();
        word_sum      = 0;
        words_dropped = 0;
      end
    endtask

    task cmp(string name, longint e, longint g);
      if (e != g) report($sformatf("%s expected %0d got %0d", name, e, g));
    endtask

    task check_stats(set_stats_t g);
      set_stats_t e;
      if (expected_stats.size() == 0) begin
        report("result word with nothing predicted");
      end else begin
        e = expected_stats.pop_front();
        cmp("item_count", longint'(e.count), longint'(g.count));
        cmp("smallest", longint'(e.smallest), longint'(g.smallest));
        cmp("largest", longint'(e.largest), longint'(g.largest));
        cmp("middle_value", longint'(e.median), longint'(g.median));
        cmp("average_q8", longint'(e.mean_q8), longint'(g.mean_q8));
        cmp("overflowed", longint'(e.dropped), longint'(g.dropped));
      end
    endtask

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [WORD_W-1:0]               in_sample_value;
  logic                                   in_set_end;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [sss_pkg::OUT_COUNT_W-1:0]        out_item_count;
  logic signed [sss_pkg::OUT_VALUE_W-1:0] out_smallest;
  logic signed [sss_pkg::OUT_VALUE_W-1:0] out_largest;
  logic signed [sss_pkg::OUT_VALUE_W-1:0] out_middle_value;
  logic signed [sss_pkg::OUT_AVG_W-1:0]   out_average_q8;
  logic                                   out_overflowed;

  sorted_set_statistics_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_count   (out_item_count),
    .out_smallest     (out_smallest),
    .out_largest      (out_largest),
    .out_middle_value (out_middle_value),
    .out_average_q8   (out_average_q8),
    .out_overflowed   (out_overflowed)
  );

  set_stats_board stats_board = new();

  int         burst_left;
  int         words_sent;
  int         idle_cycles;
  int         stall_mode;
  int         stall_mode_left;
  set_stats_t got_stats;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender: bursts of words with random gaps in between
  task send_word(logic signed [WORD_W-1:0] w, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    in_sample_value <= w;
    in_set_end      <= last;
    do @(posedge clk); while (in_stall);
    stats_board.note_word(w, last);
    burst_left--;
    words_sent++;
  endtask

  function logic signed [WORD_W-1:0] pick_word(int flavor);
    logic [31:0] r;
    r = $urandom();
    case (flavor)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return WORD_W'($signed($urandom_range(0, 16)) - 8);
      3: return {1'b1, r[14:0]};
      default: return r[WORD_W-1:0];
    endcase
  endfunction

  task send_random_set(int set_idx);
    int len;
    int flavor;
    if (set_idx % 20 == 7) begin
      // around the store size: exactly full, and words past it dropped
      len = $urandom_range(SET_DEPTH - 2, SET_DEPTH + 4);
    end else if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(9, 40);
    end else begin
      len = $urandom_range(1, 8);
    end
    flavor = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      // mostly one flavor per set so duplicates cluster
      if ($urandom_range(0, 2) == 0) send_word(pick_word($urandom_range(0, 6)), i == len - 1);
      else send_word(pick_word(flavor + 2), i == len - 1);
    end
  endtask

  // receiver stall pattern: phases of no stall, light, heavy and long runs
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(20, 200);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_stats.count    = out_item_count;
      got_stats.smallest = out_smallest;
      got_stats.largest  = out_largest;
      got_stats.median   = out_middle_value;
      got_stats.mean_q8  = out_average_q8;
      got_stats.dropped  = out_overflowed;
      stats_board.check_stats(got_stats);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int set_idx;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    in_set_end      <= 1'b0;
    burst_left      = 0;
    words_sent      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-word sets at both extremes
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b1);
    // even count whose middle sum is odd and negative: median rounds toward zero
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(-16'sd3, 1'b0);
    send_word(-16'sd4, 1'b1);
    // unsorted arrival, odd count
    send_word(16'sd5, 1'b0);
    send_word(-16'sd2, 1'b0);
    send_word(16'sd0, 1'b1);
    // equal words
    send_word(16'sd3, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sd2, 1'b0);
    send_word(16'sd2, 1'b1);
    // negative mean that does not divide evenly
    send_word(-16'sd1, 1'b0);
    send_word(-16'sd2, 1'b0);
    send_word(16'sd2, 1'b1);

    set_idx = 0;
    while (words_sent < WORD_TARGET) begin
      send_random_set(set_idx);
      set_idx++;
    end
    in_valid <= 1'b0;

    while (stats_board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stats_board.pending() != 0) stats_board.report("predicted results never arrived");
    if (stats_board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sorted_set_statistics_top.f]
hw/rtl/sss_pkg.sv
hw/rtl/sss_cell.sv
hw/rtl/sss_div.sv
hw/rtl/sorted_set_statistics_top.sv
tb/tb_sorted_set_statistics_top.sv
